>>> sv/chs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the chained hash set.
// No dependencies; imported by chs_ctrl, chs_datapath and chained_hash_set.
package chs_pkg;

   // Raw key bytes on the input bus (fixed by the interface)
   localparam int RAW_BYTES  = 9;
   // Byte sum of nine bytes fits in 12 bits (9 * 255 = 2295)
   localparam int SUM_W      = 12;
   // Bucket index width on the result bus
   localparam int BKT_W      = 6;
   // Modulo reduction: reciprocal multiply for the quotient, then the remainder
   localparam int DIV_CYCLES = 2;
   localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // Result codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic load_key;    // capture cleaned key, start hash reduction
      logic div_step;    // one step of the modulo reduction
      logic head_rd;     // read the bucket head memory
      logic head_latch;  // start the walk at the bucket head
      logic entry_rd;    // read the pool entry at the walk pointer
      logic entry_chk;   // compare entry key, follow link on miss
      logic finish;      // commit the result (and the insert, if any)
   } chs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic node_live;   // walk pointer is a taken pool entry
      logic key_match;   // fetched entry holds the key
      logic rsp_free;    // result register can take a new result
   } chs_sts_type;

endpackage

>>> sv/chs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the chained hash set: hash reduction, head read, chain walk
// and commit. Depends on chs_pkg.
module chs_ctrl
   import chs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output chs_cmd_type cmd,
   input  chs_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_HEAD,
      S_HEADW,
      S_FETCH,
      S_CMP,
      S_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_key = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_HEADW;
         end
         S_HEADW: begin
            cmd.head_latch = 1'b1;
            state_in       = S_FETCH;
         end
         S_FETCH: begin
            if (sts.node_live) begin
               cmd.entry_rd = 1'b1;
               state_in     = S_CMP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CMP: begin
            cmd.entry_chk = 1'b1;
            state_in      = sts.key_match ? S_FINISH : S_FETCH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> sv/chs_datapath.sv
`timescale 1ns / 1ps
// Datapath for the chained hash set: key cleanup and hash, bucket head
// memory, entry pool memory, walk pointer and result register. Uses chs_pkg.
module chs_datapath
   import chs_pkg::*;
#(
   parameter int BUCKETS      = 5,
   parameter int POOL_ENTRIES = 64,
   parameter int KEY_BYTES    = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_func,
   input  logic [63:0]      req_key_low,
   input  logic [7:0]       req_key_high,
   input  chs_cmd_type      cmd,
   output chs_sts_type      sts,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [2:0]       rsp_status,
   output logic [BKT_W-1:0] rsp_bucket
);

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
   localparam int HB_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int ENT_W = PTR_W + KEY_W;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_ENTRIES);
   // Rounded-up reciprocal of BUCKETS; exact quotient for any SUM_W-bit sum
   localparam int RCP_SH = SUM_W + 7;
   localparam int RCP_W  = RCP_SH + 1;
   localparam int PROD_W = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((1 << RCP_SH) + BUCKETS - 1) / BUCKETS);
   localparam logic [SUM_W-1:0] BKT_DIV = SUM_W'(BUCKETS);

   // Item registers
   logic                func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [PTR_W-1:0]    node_ff;
   logic [PTR_W-1:0]    head_ff;
   logic                hit_ff;
   logic [PTR_W-1:0]    used_ff;

   // Memories and their read registers
   logic [PTR_W-1:0]    head_mem [BUCKETS];
   logic                head_vld_ff [BUCKETS];
   logic [PTR_W-1:0]    head_rd_ff;
   logic                head_rv_ff;
   logic [ENT_W-1:0]    ent_mem [POOL_ENTRIES];
   logic [ENT_W-1:0]    ent_rd_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [BKT_W-1:0]    rsp_bucket_ff;

   logic [8*RAW_BYTES-1:0] raw_key;
   logic [8*RAW_BYTES-1:0] clean_key;
   logic [SUM_W-1:0]       key_sum;
   logic [PROD_W-1:0]      rcp_prod;
   logic [HB_W-1:0]        bkt_addr;
   logic [2:0]             status_in;
   logic                   do_insert;

   assign raw_key  = {req_key_high, req_key_low};
   assign bkt_addr = rem_ff[HB_W-1:0];

   // Cut the key at its first zero byte and at KEY_BYTES, sum the bytes
   always_comb begin
      logic       ended;
      logic [7:0] kb;
      ended   = 1'b0;
      key_sum = '0;
      for (int i = 0; i < RAW_BYTES; i++) begin
         kb = raw_key[8*i +: 8];
         if (i >= KEY_BYTES || kb == 8'd0) begin
            ended = 1'b1;
         end
         kb                 = ended ? 8'd0 : kb;
         clean_key[8*i +: 8] = kb;
         key_sum            = key_sum + SUM_W'(kb);
      end
   end

   // Modulo by reciprocal: quo_ff starts at zero, so the first step keeps
   // the sum and takes the quotient, the second subtracts quotient * BUCKETS
   assign rcp_prod = PROD_W'(rem_ff) * PROD_W'(RCP);
   assign quo_in   = rcp_prod[RCP_SH +: SUM_W];
   assign rem_in   = rem_ff - SUM_W'(quo_ff * BKT_DIV);

   // Result code for the finished walk
   always_comb begin
      do_insert = 1'b0;
      priority if (func_ff == FUNC_SEARCH) begin
         status_in = hit_ff ? ST_FOUND : ST_NOT_FOUND;
      end else if (hit_ff) begin
         status_in = ST_PRESENT;
      end else if (used_ff == NULL_PTR) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_INSERTED;
         do_insert = 1'b1;
      end
   end

   // Item and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         func_ff <= req_func;
         key_ff  <= clean_key[KEY_W-1:0];
         rem_ff  <= key_sum;
         quo_ff  <= '0;
         hit_ff  <= 1'b0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.head_latch) begin
         node_ff <= head_rv_ff ? head_rd_ff : NULL_PTR;
         head_ff <= head_rv_ff ? head_rd_ff : NULL_PTR;
      end
      // Links always point to older entries, so the walk ends within used_ff steps
      if (cmd.entry_chk) begin
         if (sts.key_match) begin
            hit_ff <= 1'b1;
         end else begin
            node_ff <= ent_rd_ff[ENT_W-1:KEY_W];
         end
      end
   end

   // Bucket head memory
   always_ff @(posedge clock) begin
      if (cmd.head_rd) begin
         head_rd_ff <= head_mem[bkt_addr];
      end
      if (cmd.finish && do_insert) begin
         head_mem[bkt_addr] <= used_ff;
      end
   end

   // Head valid bits: an unwritten head reads as null
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++) begin
            head_vld_ff[b] <= 1'b0;
         end
      end else begin
         if (cmd.head_rd) begin
            head_rv_ff <= head_vld_ff[bkt_addr];
         end
         if (cmd.finish && do_insert) begin
            head_vld_ff[bkt_addr] <= 1'b1;
         end
      end
   end

   // Entry pool memory: {next, key}
   always_ff @(posedge clock) begin
      if (cmd.entry_rd) begin
         ent_rd_ff <= ent_mem[node_ff[IDX_W-1:0]];
      end
      if (cmd.finish && do_insert) begin
         ent_mem[used_ff[IDX_W-1:0]] <= {head_ff, key_ff};
      end
   end

   // Pool allocation count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish && do_insert) begin
            used_ff <= used_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_in;
         rsp_bucket_ff <= rem_ff[BKT_W-1:0];
      end
   end

   assign sts.node_live = (node_ff < used_ff);
   assign sts.key_match = (ent_rd_ff[KEY_W-1:0] == key_ff);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_bucket = rsp_bucket_ff;

endmodule

>>> sv/chained_hash_set.sv
`timescale 1ns / 1ps
// Chained hash set: a set of short string keys (up to KEY_BYTES bytes, cut
// at the first zero byte) in BUCKETS chains over a pool of POOL_ENTRIES
// entries. One item at a time: a transfer on req_ is taken only when the
// block is idle, and one result transfer on rsp_ follows. The key is cleaned
// and summed in the accepting cycle; the item then steps through the modulo
// reduction (reciprocal multiply, then remainder), the bucket head memory
// read, a pool memory read and compare per chain entry, a check for the
// end of the chain (skipped when the key is found) and the commit, after
// which rsp_tvalid rises. req_tready comes back in the cycle the result
// appears. A result waiting on rsp_tready holds the block in its commit
// step. Storage needs no clearing pass after reset; heads carry valid bits
// and pool entries are only read below the allocation count.
// Uses chs_pkg, chs_ctrl and chs_datapath.
module chained_hash_set
   import chs_pkg::*;
#(
   parameter int BUCKETS      = 5,
   parameter int POOL_ENTRIES = 64,
   parameter int KEY_BYTES    = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // key_low[63:0], key_high[71:64]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[2:0], bucket[8:3], zero[15:9]
);

   chs_cmd_type      cmd;
   chs_sts_type      sts;
   logic [2:0]       rsp_status;
   logic [BKT_W-1:0] rsp_bucket;

   chs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   chs_datapath #(
      .BUCKETS      (BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES),
      .KEY_BYTES    (KEY_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_func     (req_tuser),
      .req_key_low  (req_tdata[63:0]),
      .req_key_high (req_tdata[71:64]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_status   (rsp_status),
      .rsp_bucket   (rsp_bucket)
   );

   // Result bus packing
   assign rsp_tdata = {7'd0, rsp_bucket, rsp_status};

endmodule

>>> sv/chs_check.sv
`timescale 1ns / 1ps
// Port-level checks for the chained hash set, bound to chained_hash_set.
// Uses chs_pkg for result codes.
module chs_check
   import chs_pkg::*;
#(
   parameter int BUCKETS = 5
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Result codes stay within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] == ST_INSERTED || rsp_tdata[2:0] == ST_PRESENT ||
                      rsp_tdata[2:0] == ST_FOUND || rsp_tdata[2:0] == ST_NOT_FOUND ||
                      rsp_tdata[2:0] == ST_FULL))
      else $error("bad status code");

   // Bucket index lies below the bucket count and the pad bits are zero
   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[8:3]) < BUCKETS) && (rsp_tdata[15:9] == 7'd0))
      else $error("bucket out of range");

   // One item at a time: busy right after an accepted transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second item while busy");

endmodule

bind chained_hash_set chs_check #(.BUCKETS(BUCKETS)) u_chs_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb_chained_hash_set.sv
`timescale 1ns / 1ps
// Self-checking testbench for chained_hash_set: a directed table, then random
// insert/search traffic checked against a shadow copy of the set.
// Depends on chs_pkg and chained_hash_set.
module tb_chained_hash_set
   import chs_pkg::*;
();

   localparam int BUCKETS      = 5;
   localparam int POOL_ENTRIES = 64;
   localparam int KEY_BYTES    = 9;

   localparam int DIR_ROWS       = 23;
   localparam int RAND_PER_PHASE = 178;
   localparam int HOLD_CYCLES    = 400;
   // drain wait covers the longest item, a walk over the whole pool
   localparam int DRAIN_CYCLES   = 160;
   localparam int STALL_LIMIT    = 5000;

   // One result: status and bucket as they travel on rsp_tdata
   typedef struct packed {
      logic [2:0] status;
      logic [5:0] bucket;
   } set_result_type;

   // One stimulus row; typed rows carry a hand-written expectation
   typedef struct packed {
      logic        func;
      logic [63:0] lo;
      logic [7:0]  hi;
      logic        typed;
      logic [2:0]  st;
      logic [5:0]  bkt;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // key_low[63:0], key_high[71:64]
   logic        req_tuser;   // func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // status[2:0], bucket[8:3], zero[15:9]

   // Shadow copy of the set
   int          shadow_head   [BUCKETS];
   logic [63:0] shadow_key_lo [POOL_ENTRIES];
   logic [7:0]  shadow_key_hi [POOL_ENTRIES];
   int          shadow_next   [POOL_ENTRIES];
   int          shadow_used;

   set_result_type pending_results [$];
   int          error_count;
   int          src_idle_pct;
   int          snk_stall_pct;
   logic        hold_go;
   int          hold_left;
   logic        hold_done;
   int          idle_cycles;

   // Directed table: empty key, garbage after the terminator, extremes,
   // unsigned high bytes, duplicates, then a deep chain in bucket 0
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{FUNC_SEARCH, 64'h0000_0000_0000_0000, 8'h00, 1'b1, ST_NOT_FOUND, 6'd0},
      '{FUNC_INSERT, 64'h0000_0000_0000_0000, 8'h00, 1'b1, ST_INSERTED,  6'd0},
      '{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF, 1'b1, ST_PRESENT,   6'd0},
      '{FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, ST_NOT_FOUND, 6'd0},
      '{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, ST_INSERTED,  6'd0},
      '{FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, ST_FOUND,     6'd0},
      '{FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, ST_NOT_FOUND, 6'd0},
      '{FUNC_INSERT, 64'h0000_0000_0000_0042, 8'h00, 1'b1, ST_INSERTED,  6'd1},
      '{FUNC_INSERT, 64'hDEAD_BEEF_CAFE_0042, 8'h77, 1'b1, ST_PRESENT,   6'd1},
      '{FUNC_SEARCH, 64'h0000_0000_0000_0042, 8'h00, 1'b1, ST_FOUND,     6'd1},
      '{FUNC_SEARCH, 64'h0000_0000_0000_4242, 8'h00, 1'b1, ST_NOT_FOUND, 6'd2},
      '{FUNC_INSERT, 64'h0101_0101_0101_0101, 8'h00, 1'b1, ST_INSERTED,  6'd3},
      '{FUNC_INSERT, 64'h0101_0101_0101_0101, 8'h01, 1'b1, ST_INSERTED,  6'd4},
      '{FUNC_SEARCH, 64'h0101_0101_0101_0101, 8'h00, 1'b1, ST_FOUND,     6'd3},
      '{FUNC_INSERT, 64'h0000_0000_0000_0000, 8'h80, 1'b1, ST_PRESENT,   6'd0},
      '{FUNC_INSERT, 64'h0000_0000_0000_0080, 8'h00, 1'b1, ST_INSERTED,  6'd3},
      '{FUNC_SEARCH, 64'h0000_0000_0000_00FF, 8'h00, 1'b1, ST_NOT_FOUND, 6'd0},
      '{FUNC_INSERT, 64'h0000_0000_0000_0005, 8'h00, 1'b0, ST_INSERTED,  6'd0},
      '{FUNC_INSERT, 64'h0000_0000_0000_000A, 8'h00, 1'b0, ST_INSERTED,  6'd0},
      '{FUNC_INSERT, 64'h0000_0000_0000_000F, 8'h00, 1'b0, ST_INSERTED,  6'd0},
      '{FUNC_SEARCH, 64'h0000_0000_0000_0005, 8'h00, 1'b0, ST_INSERTED,  6'd0},
      '{FUNC_SEARCH, 64'h0000_0000_0000_0014, 8'h00, 1'b0, ST_INSERTED,  6'd0},
      '{FUNC_INSERT, 64'h1234_5678_9ABC_000F, 8'hAA, 1'b0, ST_INSERTED,  6'd0}
   };

   chained_hash_set #(
      .BUCKETS      (BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES),
      .KEY_BYTES    (KEY_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Apply one operation to the shadow set and return its result
   function automatic set_result_type shadow_set_op(logic func, logic [63:0] lo,
                                                    logic [7:0] hi);
      logic [63:0] k_lo;
      logic [7:0]  k_hi;
      logic [7:0]  b;
      logic        ended;
      logic        hit;
      int          sum;
      int          node;
      int          steps;
      int          i;
      set_result_type res;
      k_lo  = '0;
      k_hi  = '0;
      ended = 1'b0;
      sum   = 0;
      // cut at the first zero byte and at KEY_BYTES
      for (i = 0; i < 9; i++) begin
         b = (i < 8) ? lo[8*i +: 8] : hi;
         if (i >= KEY_BYTES || b == 8'h00) ended = 1'b1;
         if (!ended) begin
            sum += b;
            if (i < 8) k_lo[8*i +: 8] = b;
            else k_hi = b;
         end
      end
      res.bucket = 6'(sum % BUCKETS);
      // chain walk, bounded and stopping at untaken entries
      node  = shadow_head[sum % BUCKETS];
      steps = 0;
      hit   = 1'b0;
      while (!hit && node < shadow_used && node < POOL_ENTRIES &&
             steps < POOL_ENTRIES) begin
         if (shadow_key_lo[node] == k_lo && shadow_key_hi[node] == k_hi) begin
            hit = 1'b1;
         end else begin
            node = shadow_next[node];
            steps++;
         end
      end
      if (func == FUNC_SEARCH) begin
         res.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end else if (hit) begin
         res.status = ST_PRESENT;
      end else if (shadow_used >= POOL_ENTRIES) begin
         res.status = ST_FULL;
      end else begin
         shadow_key_lo[shadow_used] = k_lo;
         shadow_key_hi[shadow_used] = k_hi;
         shadow_next[shadow_used]   = shadow_head[sum % BUCKETS];
         shadow_head[sum % BUCKETS] = shadow_used;
         shadow_used++;
         res.status = ST_INSERTED;
      end
      return res;
   endfunction

   // Random key: often a stored key again, with or without junk after its end
   task automatic make_key(output logic [63:0] lo, output logic [7:0] hi);
      logic [7:0] kb [9];
      int         len;
      int         pick;
      int         i;
      logic       junk;
      if (shadow_used > 0 && $urandom_range(99) < 45) begin
         pick = $urandom_range(shadow_used - 1);
         for (i = 0; i < 9; i++)
            kb[i] = (i < 8) ? shadow_key_lo[pick][8*i +: 8] : shadow_key_hi[pick];
         len = 0;
         while (len < 9 && kb[len] != 8'h00) len++;
      end else begin
         len = $urandom_range(9);
         for (i = 0; i < len; i++) kb[i] = 8'($urandom_range(1, 255));
      end
      junk = 1'($urandom_range(1));
      for (i = len; i < 9; i++)
         kb[i] = (i == len || !junk) ? 8'h00 : 8'($urandom_range(255));
      for (i = 0; i < 8; i++) lo[8*i +: 8] = kb[i];
      hi = kb[8];
   endtask

   // Offer one item, wait for its transfer, record what it should produce
   task automatic send_item(input stim_row_type r);
      set_result_type pred;
      if ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < src_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.hi, r.lo};
      req_tuser  <= r.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = shadow_set_op(r.func, r.lo, r.hi);
      if (r.typed) begin
         pred.status = r.st;
         pred.bucket = r.bkt;
      end
      pending_results.push_back(pred);
   endtask

   // Stimulus and end of run
   initial begin
      stim_row_type r;
      int        n;
      int        phase;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= FUNC_INSERT;
      error_count = 0;
      hold_go     <= 1'b0;
      for (n = 0; n < BUCKETS; n++) shadow_head[n] = POOL_ENTRIES;
      for (n = 0; n < POOL_ENTRIES; n++) shadow_next[n] = POOL_ENTRIES;
      shadow_used   = 0;
      src_idle_pct  = 11;
      snk_stall_pct <= 66;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIR_ROWS; n++) send_item(dir_rows[n]);

      // idling mix changes per phase; the last phase opens with a long
      // receiver hold-off while items keep coming
      for (phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin
               src_idle_pct  = 11;
               snk_stall_pct <= 66;
            end
            1: begin
               src_idle_pct  = 66;
               snk_stall_pct <= 11;
            end
            default: begin
               src_idle_pct  = 0;
               snk_stall_pct <= 0;
               hold_go       <= 1'b1;
            end
         endcase
         for (n = 0; n < RAND_PER_PHASE; n++) begin
            r.func  = 1'($urandom_range(1));
            r.typed = 1'b0;
            r.st    = ST_INSERTED;
            r.bkt   = '0;
            make_key(r.lo, r.hi);
            send_item(r);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Result side: random stalls, one long hold-off, compare each transfer
   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with nothing pending: %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_tdata[2:0]);
                  error_count++;
               end
               if (rsp_tdata[8:3] !== want.bucket) begin
                  $error("bucket: expected %0d, actual %0d",
                         want.bucket, rsp_tdata[8:3]);
                  error_count++;
               end
               if (rsp_tdata[15:9] !== 7'd0) begin
                  $error("pad: expected 0, actual %h", rsp_tdata[15:9]);
                  error_count++;
               end
            end
         end
         if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
         end
      end
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> sim.f
sv/chs_pkg.sv
sv/chs_ctrl.sv
sv/chs_datapath.sv
sv/chained_hash_set.sv
sv/chs_check.sv
tb/tb_chained_hash_set.sv
